/* design/ray_triangle_intersect_macros.svh */
// assertion macros shared by the checker of the ray/triangle block
`ifndef RAY_TRIANGLE_INTERSECT_MACROS_SVH
`define RAY_TRIANGLE_INTERSECT_MACROS_SVH

// condition that holds at every clock edge out of reset
`define RTI_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("rti check failed");

// consequence in the cycle after the antecedent
`define RTI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rti check failed");

`endif

/* design/rti_pkg.sv */
// shared widths, types and register codes of the ray/triangle block
`timescale 1ns / 1ps
package rti_pkg;

  localparam int CoordW   = 32;
  localparam int DiffW    = CoordW + 1;
  localparam int ProdW    = 2 * DiffW;
  localparam int MinorW   = ProdW + 1;
  localparam int LoW      = 34;
  localparam int HiW      = MinorW - LoW;
  localparam int PlW      = LoW + 1 + DiffW;
  localparam int PhW      = HiW + DiffW;
  localparam int DetW     = 104;
  localparam int NumW     = 121;
  localparam int QW       = 31;
  localparam int CmpW     = 136;
  localparam int MinW     = 31;
  localparam int NumProd  = 12;
  localparam int RndShift = 17;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 64;

  localparam logic [MinW-1:0] MinDistReset = 31'd66;

  typedef enum logic [CfgIdxW-1:0] {
    REG_A_XY     = 3'd0,
    REG_A_Z      = 3'd1,
    REG_B_XY     = 3'd2,
    REG_B_Z      = 3'd3,
    REG_C_XY     = 3'd4,
    REG_C_Z      = 3'd5,
    REG_MIN_DIST = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic signed [CoordW-1:0] ox;
    logic signed [CoordW-1:0] oy;
    logic signed [CoordW-1:0] oz;
    logic signed [CoordW-1:0] dx;
    logic signed [CoordW-1:0] dy;
    logic signed [CoordW-1:0] dz;
  } ray_t;

  typedef struct packed {
    logic signed [CoordW-1:0] ax;
    logic signed [CoordW-1:0] ay;
    logic signed [CoordW-1:0] az;
    logic signed [CoordW-1:0] bx;
    logic signed [CoordW-1:0] by;
    logic signed [CoordW-1:0] bz;
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
    logic signed [CoordW-1:0] cz;
  } tri_t;

  typedef struct packed {
    logic          miss;
    logic          sat;
    logic [QW-1:0] quo;
  } div_res_t;

endpackage

/* design/rti_det.sv */
// determinant pipeline: differences, minors and the four cramer determinants
`timescale 1ns / 1ps
module rti_det (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rti_pkg::tri_t                       tri_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  rti_pkg::ray_t                       ray_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output rti_pkg::ray_t                       ray_o,
  output logic signed [rti_pkg::DetW-1:0]     den_o,
  output logic signed [rti_pkg::DetW-1:0]     e1_o,
  output logic signed [rti_pkg::DetW-1:0]     e2_o,
  output logic signed [rti_pkg::DetW-1:0]     e3_o
);

  localparam int NS = 6;

  logic [NS-1:0] v_q;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !v_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // stage 1: edge and origin differences
  logic signed [rti_pkg::DiffW-1:0] s1_a_d, s1_b_d, s1_d_d, s1_e_d, s1_f_d;
  logic signed [rti_pkg::DiffW-1:0] s1_h_d, s1_i_d, s1_j_d, s1_l_d;
  logic signed [rti_pkg::DiffW-1:0] s1_a_q, s1_b_q, s1_d_q, s1_e_q, s1_f_q;
  logic signed [rti_pkg::DiffW-1:0] s1_h_q, s1_i_q, s1_j_q, s1_l_q;
  rti_pkg::ray_t                    s1_ray_q;

  always_comb begin
    s1_a_d = rti_pkg::DiffW'(tri_i.ax) - rti_pkg::DiffW'(tri_i.bx);
    s1_b_d = rti_pkg::DiffW'(tri_i.ax) - rti_pkg::DiffW'(tri_i.cx);
    s1_d_d = rti_pkg::DiffW'(tri_i.ax) - rti_pkg::DiffW'(ray_i.ox);
    s1_e_d = rti_pkg::DiffW'(tri_i.ay) - rti_pkg::DiffW'(tri_i.by);
    s1_f_d = rti_pkg::DiffW'(tri_i.ay) - rti_pkg::DiffW'(tri_i.cy);
    s1_h_d = rti_pkg::DiffW'(tri_i.ay) - rti_pkg::DiffW'(ray_i.oy);
    s1_i_d = rti_pkg::DiffW'(tri_i.az) - rti_pkg::DiffW'(tri_i.bz);
    s1_j_d = rti_pkg::DiffW'(tri_i.az) - rti_pkg::DiffW'(tri_i.cz);
    s1_l_d = rti_pkg::DiffW'(tri_i.az) - rti_pkg::DiffW'(ray_i.oz);
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_a_q   <= s1_a_d;
      s1_b_q   <= s1_b_d;
      s1_d_q   <= s1_d_d;
      s1_e_q   <= s1_e_d;
      s1_f_q   <= s1_f_d;
      s1_h_q   <= s1_h_d;
      s1_i_q   <= s1_i_d;
      s1_j_q   <= s1_j_d;
      s1_l_q   <= s1_l_d;
      s1_ray_q <= ray_i;
    end
  end

  // stage 2: products for the 2x2 minors
  logic signed [rti_pkg::DiffW-1:0] dy_x, dz_x;
  logic signed [rti_pkg::ProdW-1:0] p_d [12];
  logic signed [rti_pkg::ProdW-1:0] p_q [12];
  logic signed [rti_pkg::DiffW-1:0] s2_a_q, s2_b_q, s2_d_q;
  rti_pkg::ray_t                    s2_ray_q;

  always_comb begin
    dy_x    = rti_pkg::DiffW'(s1_ray_q.dy);
    dz_x    = rti_pkg::DiffW'(s1_ray_q.dz);
    p_d[0]  = rti_pkg::ProdW'(s1_f_q) * rti_pkg::ProdW'(dz_x);
    p_d[1]  = rti_pkg::ProdW'(dy_x) * rti_pkg::ProdW'(s1_j_q);
    p_d[2]  = rti_pkg::ProdW'(s1_h_q) * rti_pkg::ProdW'(dz_x);
    p_d[3]  = rti_pkg::ProdW'(dy_x) * rti_pkg::ProdW'(s1_l_q);
    p_d[4]  = rti_pkg::ProdW'(s1_f_q) * rti_pkg::ProdW'(s1_l_q);
    p_d[5]  = rti_pkg::ProdW'(s1_h_q) * rti_pkg::ProdW'(s1_j_q);
    p_d[6]  = rti_pkg::ProdW'(dy_x) * rti_pkg::ProdW'(s1_i_q);
    p_d[7]  = rti_pkg::ProdW'(s1_e_q) * rti_pkg::ProdW'(dz_x);
    p_d[8]  = rti_pkg::ProdW'(s1_e_q) * rti_pkg::ProdW'(s1_j_q);
    p_d[9]  = rti_pkg::ProdW'(s1_f_q) * rti_pkg::ProdW'(s1_i_q);
    p_d[10] = rti_pkg::ProdW'(s1_e_q) * rti_pkg::ProdW'(s1_l_q);
    p_d[11] = rti_pkg::ProdW'(s1_h_q) * rti_pkg::ProdW'(s1_i_q);
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      for (int k = 0; k < 12; k++) begin
        p_q[k] <= p_d[k];
      end
      s2_a_q   <= s1_a_q;
      s2_b_q   <= s1_b_q;
      s2_d_q   <= s1_d_q;
      s2_ray_q <= s1_ray_q;
    end
  end

  // stage 3: minors m n p q s r
  logic signed [rti_pkg::MinorW-1:0] mn_m_q, mn_n_q, mn_p_q, mn_q_q, mn_s_q, mn_r_q;
  logic signed [rti_pkg::DiffW-1:0]  s3_a_q, s3_b_q, s3_d_q;
  rti_pkg::ray_t                     s3_ray_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      mn_m_q   <= rti_pkg::MinorW'(p_q[0])  - rti_pkg::MinorW'(p_q[1]);
      mn_n_q   <= rti_pkg::MinorW'(p_q[2])  - rti_pkg::MinorW'(p_q[3]);
      mn_p_q   <= rti_pkg::MinorW'(p_q[4])  - rti_pkg::MinorW'(p_q[5]);
      mn_q_q   <= rti_pkg::MinorW'(p_q[6])  - rti_pkg::MinorW'(p_q[7]);
      mn_s_q   <= rti_pkg::MinorW'(p_q[8])  - rti_pkg::MinorW'(p_q[9]);
      mn_r_q   <= rti_pkg::MinorW'(p_q[10]) - rti_pkg::MinorW'(p_q[11]);
      s3_a_q   <= s2_a_q;
      s3_b_q   <= s2_b_q;
      s3_d_q   <= s2_d_q;
      s3_ray_q <= s2_ray_q;
    end
  end

  // stage 4: minor times factor, split into two partial products per lane
  logic signed [rti_pkg::MinorW-1:0] mn [rti_pkg::NumProd];
  logic signed [rti_pkg::DiffW-1:0]  fac [rti_pkg::NumProd];
  logic signed [rti_pkg::DiffW-1:0]  dx_x;
  logic signed [rti_pkg::PlW-1:0]    pl_d [rti_pkg::NumProd];
  logic signed [rti_pkg::PhW-1:0]    ph_d [rti_pkg::NumProd];
  logic signed [rti_pkg::PlW-1:0]    pl_q [rti_pkg::NumProd];
  logic signed [rti_pkg::PhW-1:0]    ph_q [rti_pkg::NumProd];
  rti_pkg::ray_t                     s4_ray_q;

  always_comb begin
    dx_x = rti_pkg::DiffW'(s3_ray_q.dx);
    // den: ma qb sc, e1: md nb pc, e2: na qd rc, e3: pa rb sd
    mn[0]  = mn_m_q;  fac[0]  = s3_a_q;
    mn[1]  = mn_q_q;  fac[1]  = s3_b_q;
    mn[2]  = mn_s_q;  fac[2]  = dx_x;
    mn[3]  = mn_m_q;  fac[3]  = s3_d_q;
    mn[4]  = mn_n_q;  fac[4]  = s3_b_q;
    mn[5]  = mn_p_q;  fac[5]  = dx_x;
    mn[6]  = mn_n_q;  fac[6]  = s3_a_q;
    mn[7]  = mn_q_q;  fac[7]  = s3_d_q;
    mn[8]  = mn_r_q;  fac[8]  = dx_x;
    mn[9]  = mn_p_q;  fac[9]  = s3_a_q;
    mn[10] = mn_r_q;  fac[10] = s3_b_q;
    mn[11] = mn_s_q;  fac[11] = s3_d_q;
    for (int k = 0; k < rti_pkg::NumProd; k++) begin
      pl_d[k] = rti_pkg::PlW'($signed({1'b0, mn[k][rti_pkg::LoW-1:0]}))
                * rti_pkg::PlW'(fac[k]);
      ph_d[k] = rti_pkg::PhW'($signed(mn[k][rti_pkg::MinorW-1:rti_pkg::LoW]))
                * rti_pkg::PhW'(fac[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      for (int k = 0; k < rti_pkg::NumProd; k++) begin
        pl_q[k] <= pl_d[k];
        ph_q[k] <= ph_d[k];
      end
      s4_ray_q <= s3_ray_q;
    end
  end

  // stage 5: recombine partial products
  logic signed [rti_pkg::DetW-1:0] full_q [rti_pkg::NumProd];
  rti_pkg::ray_t                   s5_ray_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      for (int k = 0; k < rti_pkg::NumProd; k++) begin
        full_q[k] <= (rti_pkg::DetW'(ph_q[k]) <<< rti_pkg::LoW) + rti_pkg::DetW'(pl_q[k]);
      end
      s5_ray_q <= s4_ray_q;
    end
  end

  // stage 6: three-term determinant sums
  logic signed [rti_pkg::DetW-1:0] den_q, e1_q, e2_q, e3_q;
  rti_pkg::ray_t                   s6_ray_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      den_q    <= full_q[0] + full_q[1] + full_q[2];
      e1_q     <= full_q[3] - full_q[4] - full_q[5];
      e2_q     <= full_q[6] + full_q[7] + full_q[8];
      e3_q     <= full_q[9] - full_q[10] + full_q[11];
      s6_ray_q <= s5_ray_q;
    end
  end

  assign den_o = den_q;
  assign e1_o  = e1_q;
  assign e2_o  = e2_q;
  assign e3_o  = e3_q;
  assign ray_o = s6_ray_q;

endmodule

/* design/rti_div.sv */
// inside tests and pipelined restoring division for the ray parameter
`timescale 1ns / 1ps
module rti_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  rti_pkg::ray_t                   ray_i,
  input  logic signed [rti_pkg::DetW-1:0] den_i,
  input  logic signed [rti_pkg::DetW-1:0] e1_i,
  input  logic signed [rti_pkg::DetW-1:0] e2_i,
  input  logic signed [rti_pkg::DetW-1:0] e3_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output rti_pkg::ray_t                   ray_o,
  output rti_pkg::div_res_t               res_o
);

  localparam int NS    = 3 + rti_pkg::QW;
  localparam int GapW  = rti_pkg::DetW + 2;
  localparam int NumXW = rti_pkg::NumW + 1;

  logic [NS-1:0] v_q;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !v_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // stage a: make the denominator positive
  logic signed [rti_pkg::DetW-1:0] na_den_q, na_e1_q, na_e2_q, na_e3_q;
  logic                            na_zero_q;
  rti_pkg::ray_t                   na_ray_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      na_den_q  <= den_i[rti_pkg::DetW-1] ? -den_i : den_i;
      na_e1_q   <= den_i[rti_pkg::DetW-1] ? -e1_i  : e1_i;
      na_e2_q   <= den_i[rti_pkg::DetW-1] ? -e2_i  : e2_i;
      na_e3_q   <= den_i[rti_pkg::DetW-1] ? -e3_i  : e3_i;
      na_zero_q <= (den_i == '0);
      na_ray_q  <= ray_i;
    end
  end

  // stage b: barycentric tests and rounded numerator
  logic signed [GapW-1:0]          gap_d;
  logic signed [NumXW-1:0]         num_d;
  logic                            nb_miss_d;
  logic                            nb_miss_q;
  logic [rti_pkg::NumW-1:0]        nb_num_q;
  logic [rti_pkg::DetW-1:0]        nb_den2_q;
  rti_pkg::ray_t                   nb_ray_q;

  always_comb begin
    gap_d     = GapW'(na_den_q) - GapW'(na_e1_q) - GapW'(na_e2_q);
    num_d     = (NumXW'(na_e3_q) <<< rti_pkg::RndShift) + NumXW'(na_den_q);
    nb_miss_d = na_zero_q || na_e1_q[rti_pkg::DetW-1] || na_e2_q[rti_pkg::DetW-1]
                || gap_d[GapW-1] || num_d[NumXW-1];
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      nb_miss_q <= nb_miss_d;
      nb_num_q  <= num_d[rti_pkg::NumW-1:0];
      nb_den2_q <= {na_den_q[rti_pkg::DetW-2:0], 1'b0};
      nb_ray_q  <= na_ray_q;
    end
  end

  // stage c and the quotient stages, one quotient bit per stage
  logic [rti_pkg::NumW-1:0] it_rem_q  [rti_pkg::QW+1];
  logic [rti_pkg::DetW-1:0] it_den_q  [rti_pkg::QW+1];
  logic [rti_pkg::QW-1:0]   it_quo_q  [rti_pkg::QW+1];
  logic                     it_miss_q [rti_pkg::QW+1];
  logic                     it_sat_q  [rti_pkg::QW+1];
  rti_pkg::ray_t            it_ray_q  [rti_pkg::QW+1];

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      it_rem_q[0]  <= nb_num_q;
      it_den_q[0]  <= nb_den2_q;
      it_quo_q[0]  <= '0;
      it_miss_q[0] <= nb_miss_q;
      it_sat_q[0]  <= rti_pkg::CmpW'(nb_num_q)
                      >= (rti_pkg::CmpW'(nb_den2_q) << rti_pkg::QW);
      it_ray_q[0]  <= nb_ray_q;
    end
  end

  for (genvar g = 0; g < rti_pkg::QW; g++) begin : g_quo
    localparam int Bit = rti_pkg::QW - 1 - g;
    logic [rti_pkg::CmpW-1:0] shifted;
    logic                     ge;
    logic [rti_pkg::QW-1:0]   quo_d;

    always_comb begin
      shifted    = rti_pkg::CmpW'(it_den_q[g]) << Bit;
      ge         = rti_pkg::CmpW'(it_rem_q[g]) >= shifted;
      quo_d      = it_quo_q[g];
      quo_d[Bit] = ge;
    end

    always_ff @(posedge clk_i) begin
      if (en[3+g]) begin
        it_rem_q[g+1]  <= ge ? it_rem_q[g] - shifted[rti_pkg::NumW-1:0] : it_rem_q[g];
        it_den_q[g+1]  <= it_den_q[g];
        it_quo_q[g+1]  <= quo_d;
        it_miss_q[g+1] <= it_miss_q[g];
        it_sat_q[g+1]  <= it_sat_q[g];
        it_ray_q[g+1]  <= it_ray_q[g];
      end
    end
  end

  assign ray_o      = it_ray_q[rti_pkg::QW];
  assign res_o.miss = it_miss_q[rti_pkg::QW];
  assign res_o.sat  = it_sat_q[rti_pkg::QW];
  assign res_o.quo  = it_quo_q[rti_pkg::QW];

endmodule

/* design/rti_point.sv */
// minimum distance test, hit point and output register
`timescale 1ns / 1ps
module rti_point (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [rti_pkg::MinW-1:0]          min_dist_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  rti_pkg::ray_t                     ray_i,
  input  rti_pkg::div_res_t                 res_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              hit_o,
  output logic signed [rti_pkg::CoordW-1:0] distance_o,
  output logic signed [rti_pkg::CoordW-1:0] point_x_o,
  output logic signed [rti_pkg::CoordW-1:0] point_y_o,
  output logic signed [rti_pkg::CoordW-1:0] point_z_o
);

  localparam int NS   = 3;
  localparam int PW   = 2 * rti_pkg::CoordW;
  localparam int SW   = PW + 1;
  localparam int Frac = 16;

  logic [NS-1:0] v_q;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !v_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  function automatic logic signed [rti_pkg::CoordW-1:0] round_sat(
    input logic signed [SW-1:0] sum
  );
    logic signed [SW-1:0]   rnd;
    logic [SW-Frac-1:0]     top;
    logic                   in_range;
    rnd      = sum + SW'(1 << (Frac - 1));
    top      = rnd[SW-1:Frac];
    in_range = (top[SW-Frac-1:rti_pkg::CoordW-1] == '0)
               || (top[SW-Frac-1:rti_pkg::CoordW-1] == '1);
    if (in_range) begin
      return top[rti_pkg::CoordW-1:0];
    end else if (top[SW-Frac-1]) begin
      return {1'b1, {(rti_pkg::CoordW-1){1'b0}}};
    end else begin
      return {1'b0, {(rti_pkg::CoordW-1){1'b1}}};
    end
  endfunction

  // stage 1: saturate t and check the minimum distance
  logic [rti_pkg::QW-1:0] t_d;
  logic [rti_pkg::QW-1:0] s1_t_q;
  logic                   s1_miss_q;
  rti_pkg::ray_t          s1_ray_q;

  assign t_d = res_i.sat ? {rti_pkg::QW{1'b1}} : res_i.quo;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_t_q    <= t_d;
      s1_miss_q <= res_i.miss || (t_d < min_dist_i);
      s1_ray_q  <= ray_i;
    end
  end

  // stage 2: direction times t
  logic signed [rti_pkg::CoordW-1:0] t_s;
  logic signed [PW-1:0]              s2_px_q, s2_py_q, s2_pz_q;
  logic [rti_pkg::QW-1:0]            s2_t_q;
  logic                              s2_miss_q;
  rti_pkg::ray_t                     s2_ray_q;

  assign t_s = $signed({1'b0, s1_t_q});

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s2_px_q   <= PW'(s1_ray_q.dx) * PW'(t_s);
      s2_py_q   <= PW'(s1_ray_q.dy) * PW'(t_s);
      s2_pz_q   <= PW'(s1_ray_q.dz) * PW'(t_s);
      s2_t_q    <= s1_t_q;
      s2_miss_q <= s1_miss_q;
      s2_ray_q  <= s1_ray_q;
    end
  end

  // stage 3: add origin, round, saturate, zero on a miss
  logic signed [SW-1:0] sx_d, sy_d, sz_d;
  logic                 hit_q;
  logic signed [rti_pkg::CoordW-1:0] dist_q, px_q, py_q, pz_q;

  always_comb begin
    sx_d = (SW'(s2_ray_q.ox) <<< Frac) + SW'(s2_px_q);
    sy_d = (SW'(s2_ray_q.oy) <<< Frac) + SW'(s2_py_q);
    sz_d = (SW'(s2_ray_q.oz) <<< Frac) + SW'(s2_pz_q);
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      hit_q  <= !s2_miss_q;
      dist_q <= s2_miss_q ? '0 : $signed({1'b0, s2_t_q});
      px_q   <= s2_miss_q ? '0 : round_sat(sx_d);
      py_q   <= s2_miss_q ? '0 : round_sat(sy_d);
      pz_q   <= s2_miss_q ? '0 : round_sat(sz_d);
    end
  end

  assign hit_o      = hit_q;
  assign distance_o = dist_q;
  assign point_x_o  = px_q;
  assign point_y_o  = py_q;
  assign point_z_o  = pz_q;

endmodule

/* design/ray_triangle_intersect.sv */
// top level of the ray/triangle intersection block, cramer's rule in fixed point
// pipeline: determinant section, then divide section, then point section
// throughput: one ray per cycle while the result side is ready; a full stage holds while its successor cannot move
// the divider yields one quotient bit per stage, which sets its 31 quotient stages
// reset: async active low, clears valid bits and loads register defaults
`timescale 1ns / 1ps
module ray_triangle_intersect (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rti_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [rti_pkg::CfgDataW-1:0]      cfg_data_i,
  // ray input channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [rti_pkg::CoordW-1:0] origin_x_i,
  input  logic signed [rti_pkg::CoordW-1:0] origin_y_i,
  input  logic signed [rti_pkg::CoordW-1:0] origin_z_i,
  input  logic signed [rti_pkg::CoordW-1:0] direction_x_i,
  input  logic signed [rti_pkg::CoordW-1:0] direction_y_i,
  input  logic signed [rti_pkg::CoordW-1:0] direction_z_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              hit_o,
  output logic signed [rti_pkg::CoordW-1:0] distance_o,
  output logic signed [rti_pkg::CoordW-1:0] point_x_o,
  output logic signed [rti_pkg::CoordW-1:0] point_y_o,
  output logic signed [rti_pkg::CoordW-1:0] point_z_o
);

  // configuration registers; the host is to write them only while the pipe is empty, the block does not enforce it
  logic [rti_pkg::CfgDataW-1:0] a_xy_q, b_xy_q, c_xy_q;
  logic [rti_pkg::CoordW-1:0]   a_z_q, b_z_q, c_z_q;
  logic [rti_pkg::MinW-1:0]     min_dist_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_xy_q     <= '0;
      b_xy_q     <= '0;
      c_xy_q     <= '0;
      a_z_q      <= '0;
      b_z_q      <= '0;
      c_z_q      <= '0;
      min_dist_q <= rti_pkg::MinDistReset;
    end else if (cfg_valid_i) begin
      unique case (rti_pkg::cfg_reg_e'(cfg_index_i))
        rti_pkg::REG_A_XY:     a_xy_q     <= cfg_data_i;
        rti_pkg::REG_A_Z:      a_z_q      <= cfg_data_i[rti_pkg::CoordW-1:0];
        rti_pkg::REG_B_XY:     b_xy_q     <= cfg_data_i;
        rti_pkg::REG_B_Z:      b_z_q      <= cfg_data_i[rti_pkg::CoordW-1:0];
        rti_pkg::REG_C_XY:     c_xy_q     <= cfg_data_i;
        rti_pkg::REG_C_Z:      c_z_q      <= cfg_data_i[rti_pkg::CoordW-1:0];
        rti_pkg::REG_MIN_DIST: min_dist_q <= cfg_data_i[rti_pkg::MinW-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // unpack vertices: x in the upper half, y in the lower half
  rti_pkg::tri_t tri_cfg;
  rti_pkg::ray_t ray_in;

  always_comb begin
    tri_cfg.ax = a_xy_q[2*rti_pkg::CoordW-1:rti_pkg::CoordW];
    tri_cfg.ay = a_xy_q[rti_pkg::CoordW-1:0];
    tri_cfg.az = a_z_q;
    tri_cfg.bx = b_xy_q[2*rti_pkg::CoordW-1:rti_pkg::CoordW];
    tri_cfg.by = b_xy_q[rti_pkg::CoordW-1:0];
    tri_cfg.bz = b_z_q;
    tri_cfg.cx = c_xy_q[2*rti_pkg::CoordW-1:rti_pkg::CoordW];
    tri_cfg.cy = c_xy_q[rti_pkg::CoordW-1:0];
    tri_cfg.cz = c_z_q;
    ray_in.ox = origin_x_i;
    ray_in.oy = origin_y_i;
    ray_in.oz = origin_z_i;
    ray_in.dx = direction_x_i;
    ray_in.dy = direction_y_i;
    ray_in.dz = direction_z_i;
  end

  // determinant section
  logic                            det_valid, det_ready;
  rti_pkg::ray_t                   det_ray;
  logic signed [rti_pkg::DetW-1:0] det_den, det_e1, det_e2, det_e3;

  rti_det u_det (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tri_i       (tri_cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .ray_i       (ray_in),
    .out_valid_o (det_valid),
    .out_ready_i (det_ready),
    .ray_o       (det_ray),
    .den_o       (det_den),
    .e1_o        (det_e1),
    .e2_o        (det_e2),
    .e3_o        (det_e3)
  );

  // inside tests and t division
  logic              div_valid, div_ready;
  rti_pkg::ray_t     div_ray;
  rti_pkg::div_res_t div_res;

  rti_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (det_valid),
    .in_ready_o  (det_ready),
    .ray_i       (det_ray),
    .den_i       (det_den),
    .e1_i        (det_e1),
    .e2_i        (det_e2),
    .e3_i        (det_e3),
    .out_valid_o (div_valid),
    .out_ready_i (div_ready),
    .ray_o       (div_ray),
    .res_o       (div_res)
  );

  // minimum distance, hit point and output register
  rti_point u_point (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .min_dist_i  (min_dist_q),
    .in_valid_i  (div_valid),
    .in_ready_o  (div_ready),
    .ray_i       (div_ray),
    .res_i       (div_res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .hit_o       (hit_o),
    .distance_o  (distance_o),
    .point_x_o   (point_x_o),
    .point_y_o   (point_y_o),
    .point_z_o   (point_z_o)
  );

endmodule

/* design/rti_checker.sv */
// port-level checker for the ray/triangle block and its bind
`timescale 1ns / 1ps
`include "ray_triangle_intersect_macros.svh"
module rti_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic                              hit_o,
  input logic signed [rti_pkg::CoordW-1:0] distance_o,
  input logic signed [rti_pkg::CoordW-1:0] point_x_o,
  input logic signed [rti_pkg::CoordW-1:0] point_y_o,
  input logic signed [rti_pkg::CoordW-1:0] point_z_o
);

  // rays in flight
  logic [6:0] cnt_q, cnt_d;

  assign cnt_d = cnt_q + 7'(in_valid_i && in_ready_o) - 7'(out_valid_o && out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  `RTI_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
    out_valid_o && $stable(hit_o) && $stable(distance_o) && $stable(point_x_o))

  `RTI_ASSERT_ALWAYS(a_miss_zero, !(out_valid_o && !hit_o) || (distance_o == '0
    && point_x_o == '0 && point_y_o == '0 && point_z_o == '0))

  `RTI_ASSERT_ALWAYS(a_hit_dist_pos, !(out_valid_o && hit_o) || !distance_o[31])

  `RTI_ASSERT_ALWAYS(a_no_phantom, !out_valid_o || (cnt_q != '0))

endmodule

bind ray_triangle_intersect rti_checker u_rti_checker (.*);

/* sim/ray_triangle_intersect_tb.sv */
// self-checking testbench of the ray/triangle intersection block
`timescale 1ns / 1ps
module ray_triangle_intersect_tb;

  localparam int  One        = 65536;
  localparam int  CycleLimit = 100000;
  localparam int  DrainWait  = 60;
  localparam int  LongHold   = 300;
  localparam int  ItemsPerPh = 170;
  localparam int  NumPhases  = 6;
  localparam longint MaxT    = 64'h7fffffff;
  localparam int  CW         = rti_pkg::CoordW;

  // one result transaction as the block presents it
  typedef struct {
    logic                 hit;
    logic signed [CW-1:0] distance;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic signed [CW-1:0] pz;
  } hit_res_t;

  // a directed row: ray, and a typed expectation where it is obvious
  typedef struct {
    rti_pkg::ray_t ray;
    bit            known;
    hit_res_t      res;
  } ray_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [rti_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic [rti_pkg::CfgDataW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [CW-1:0] origin_x_i = '0, origin_y_i = '0, origin_z_i = '0;
  logic signed [CW-1:0] direction_x_i = '0, direction_y_i = '0, direction_z_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic hit_o;
  logic signed [CW-1:0] distance_o, point_x_o, point_y_o, point_z_o;

  ray_triangle_intersect DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow copy of the configuration registers, updated on each config transaction
  rti_pkg::tri_t                tri_shadow;
  logic [rti_pkg::MinW-1:0]     min_dist_shadow;

  hit_res_t expected_hits[$];
  int       err_count = 0;
  int       cycle_count = 0;

  // side information that travels with the ray on the input channel
  bit       row_known = 1'b0;
  hit_res_t row_res;

  // receiver control
  bit calm = 1'b0;
  int hold_left = 0;
  int burst_left = 0;

  function automatic logic signed [127:0] wide(longint v);
    return 128'(v);
  endfunction

  // origin plus direction times t, rounded half up, saturated
  function automatic logic signed [CW-1:0] hit_coord(longint o, longint dir, longint t);
    longint sum;
    logic signed [79:0] r;
    sum = o * 65536 + dir * t;
    r = (80'(sum) + 80'sd32768) >>> 16;
    if (r > 80'sd2147483647) return 32'sh7fffffff;
    if (r < -80'sd2147483648) return 32'sh80000000;
    return r[CW-1:0];
  endfunction

  // cramer's rule with exact determinants, t rounded and saturated
  function automatic hit_res_t predict_hit(rti_pkg::ray_t r);
    hit_res_t res;
    longint a, b, c, d, e, f, g, h, i, j, k, l, t;
    logic signed [127:0] m, n, p, q, s, rm, den, e1, e2, e3, num, quo;
    res = '{1'b0, '0, '0, '0, '0};
    a = longint'(tri_shadow.ax) - longint'(tri_shadow.bx);
    b = longint'(tri_shadow.ax) - longint'(tri_shadow.cx);
    c = longint'(r.dx);
    d = longint'(tri_shadow.ax) - longint'(r.ox);
    e = longint'(tri_shadow.ay) - longint'(tri_shadow.by);
    f = longint'(tri_shadow.ay) - longint'(tri_shadow.cy);
    g = longint'(r.dy);
    h = longint'(tri_shadow.ay) - longint'(r.oy);
    i = longint'(tri_shadow.az) - longint'(tri_shadow.bz);
    j = longint'(tri_shadow.az) - longint'(tri_shadow.cz);
    k = longint'(r.dz);
    l = longint'(tri_shadow.az) - longint'(r.oz);
    m  = wide(f) * wide(k) - wide(g) * wide(j);
    n  = wide(h) * wide(k) - wide(g) * wide(l);
    p  = wide(f) * wide(l) - wide(h) * wide(j);
    q  = wide(g) * wide(i) - wide(e) * wide(k);
    s  = wide(e) * wide(j) - wide(f) * wide(i);
    rm = wide(e) * wide(l) - wide(h) * wide(i);
    den = m * wide(a) + q * wide(b) + s * wide(c);
    e1  = m * wide(d) - n * wide(b) - p * wide(c);
    e2  = n * wide(a) + q * wide(d) + rm * wide(c);
    e3  = p * wide(a) - rm * wide(b) + s * wide(d);
    // parallel ray or degenerate triangle
    if (den == 0) return res;
    if (den < 0) begin
      den = -den;
      e1 = -e1;
      e2 = -e2;
      e3 = -e3;
    end
    if (e1 < 0 || e2 < 0) return res;
    if (den - (e1 + e2) < 0) return res;
    num = (e3 <<< rti_pkg::RndShift) + den;
    if (num < 0) return res;
    quo = num / (den <<< 1);
    t = (quo > wide(MaxT)) ? MaxT : longint'(quo);
    if (t < longint'(min_dist_shadow)) return res;
    res.hit      = 1'b1;
    res.distance = t[CW-1:0];
    res.px       = hit_coord(longint'(r.ox), longint'(r.dx), t);
    res.py       = hit_coord(longint'(r.oy), longint'(r.dy), t);
    res.pz       = hit_coord(longint'(r.oz), longint'(r.dz), t);
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // input and config transactions feed the shadow state, results are checked
  always @(posedge clk_i) begin
    hit_res_t want;
    cycle_count <= cycle_count + 1;
    if (cfg_valid_i && cfg_ready_o) begin
      case (rti_pkg::cfg_reg_e'(cfg_index_i))
        rti_pkg::REG_A_XY:     {tri_shadow.ax, tri_shadow.ay} = cfg_data_i;
        rti_pkg::REG_A_Z:      tri_shadow.az = cfg_data_i[CW-1:0];
        rti_pkg::REG_B_XY:     {tri_shadow.bx, tri_shadow.by} = cfg_data_i;
        rti_pkg::REG_B_Z:      tri_shadow.bz = cfg_data_i[CW-1:0];
        rti_pkg::REG_C_XY:     {tri_shadow.cx, tri_shadow.cy} = cfg_data_i;
        rti_pkg::REG_C_Z:      tri_shadow.cz = cfg_data_i[CW-1:0];
        rti_pkg::REG_MIN_DIST: min_dist_shadow = cfg_data_i[rti_pkg::MinW-1:0];
        default: ;
      endcase
    end
    if (in_valid_i && in_ready_o)
      expected_hits.push_back(row_known ? row_res
          : predict_hit('{origin_x_i, origin_y_i, origin_z_i,
                          direction_x_i, direction_y_i, direction_z_i}));
    if (out_valid_o && out_ready_i) begin
      if (expected_hits.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = expected_hits.pop_front();
        if (hit_o !== want.hit) report_mismatch("hit", hit_o, want.hit);
        if (distance_o !== want.distance)
          report_mismatch("distance", distance_o, want.distance);
        if (point_x_o !== want.px) report_mismatch("point_x", point_x_o, want.px);
        if (point_y_o !== want.py) report_mismatch("point_y", point_y_o, want.py);
        if (point_z_o !== want.pz) report_mismatch("point_z", point_z_o, want.pz);
      end
    end
  end

  // generous cycle limit
  always @(posedge clk_i) begin
    if (cycle_count > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: a long hold-off when asked, always ready when calm, otherwise random stall bursts
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (calm) begin
        out_ready_i <= 1'b1;
      end else if (burst_left > 0) begin
        out_ready_i <= 1'b0;
        burst_left--;
      end else if ($urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        burst_left = $urandom_range(0, 9);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send_ray(rti_pkg::ray_t r, bit known, hit_res_t res);
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    origin_x_i    <= r.ox;
    origin_y_i    <= r.oy;
    origin_z_i    <= r.oz;
    direction_x_i <= r.dx;
    direction_y_i <= r.dy;
    direction_z_i <= r.dz;
    row_known     <= known;
    row_res       <= res;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // sender gap: lower valid between rays
  task automatic idle_gap();
    int n;
    n = $urandom_range(1, 10);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  // lower valid and wait out every outstanding result
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  task automatic write_reg(rti_pkg::cfg_reg_e idx, logic [rti_pkg::CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic load_triangle(rti_pkg::tri_t t, logic [rti_pkg::MinW-1:0] md);
    write_reg(rti_pkg::REG_A_XY, {t.ax, t.ay});
    write_reg(rti_pkg::REG_A_Z, {$urandom(), t.az});
    write_reg(rti_pkg::REG_B_XY, {t.bx, t.by});
    write_reg(rti_pkg::REG_B_Z, {$urandom(), t.bz});
    write_reg(rti_pkg::REG_C_XY, {t.cx, t.cy});
    write_reg(rti_pkg::REG_C_Z, {$urandom(), t.cz});
    write_reg(rti_pkg::REG_MIN_DIST, {$urandom(), $urandom()} & ~64'h7fffffff | 64'(md));
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic signed [CW-1:0] small_coord();
    return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
  endfunction

  // ray aimed at a point in or near the triangle, with random content
  function automatic rti_pkg::ray_t aimed_ray();
    rti_pkg::ray_t r;
    longint bw, gw, tq, px, py, pz;
    if ($urandom_range(0, 7) == 0) begin
      r = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
      return r;
    end
    bw = $urandom_range(0, 300);
    gw = $urandom_range(0, 300 - bw);
    px = tri_shadow.ax + ((longint'(tri_shadow.bx) - tri_shadow.ax) * bw
                       + (longint'(tri_shadow.cx) - tri_shadow.ax) * gw) / 256;
    py = tri_shadow.ay + ((longint'(tri_shadow.by) - tri_shadow.ay) * bw
                       + (longint'(tri_shadow.cy) - tri_shadow.ay) * gw) / 256;
    pz = tri_shadow.az + ((longint'(tri_shadow.bz) - tri_shadow.az) * bw
                       + (longint'(tri_shadow.cz) - tri_shadow.az) * gw) / 256;
    r.dx = $signed($urandom_range(0, 1 << 19)) - (1 << 18);
    r.dy = $signed($urandom_range(0, 1 << 19)) - (1 << 18);
    r.dz = $signed($urandom_range(0, 1 << 19)) - (1 << 18);
    // mostly in front of the origin, sometimes behind
    tq = longint'($urandom_range(0, 28)) - 4;
    r.ox = CW'(px - longint'(r.dx) * tq / 4);
    r.oy = CW'(py - longint'(r.dy) * tq / 4);
    r.oz = CW'(pz - longint'(r.dz) * tq / 4);
    return r;
  endfunction

  ray_row_t reset_rows[4];
  ray_row_t tri_rows[14];
  hit_res_t miss_res;
  hit_res_t unit_hit;
  rti_pkg::tri_t            tri_sel;
  logic [rti_pkg::MinW-1:0] md_sel;

  initial begin
    miss_res = '{1'b0, '0, '0, '0, '0};
    unit_hit = '{1'b1, 5 * One, One, One, '0};
    tri_shadow = '0;
    min_dist_shadow = rti_pkg::MinDistReset;
    // after reset every vertex is zero: degenerate, so always a miss
    reset_rows[0] = '{'{'0, '0, '0, '0, '0, '0}, 1'b1, miss_res};
    reset_rows[1] = '{'{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                        32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff}, 1'b1, miss_res};
    reset_rows[2] = '{'{32'sh80000000, 32'sh80000000, 32'sh80000000,
                        32'sh80000000, 32'sh80000000, 32'sh80000000}, 1'b1, miss_res};
    reset_rows[3] = '{'{One, One, -5 * One, '0, '0, One}, 1'b1, miss_res};
    // right triangle in the z = 0 plane with legs of four units
    tri_rows[0]  = '{'{One, One, -5 * One, '0, '0, One}, 1'b1, unit_hit};
    tri_rows[1]  = '{'{One, One, -5 * One, '0, '0, '0}, 1'b1, miss_res};
    tri_rows[2]  = '{'{One, One, -5 * One, One, '0, '0}, 1'b1, miss_res};
    tri_rows[3]  = '{'{One, One, 5 * One, '0, '0, One}, 1'b1, miss_res};
    tri_rows[4]  = '{'{5 * One, 5 * One, -One, '0, '0, One}, 1'b1, miss_res};
    // edge beta + gamma = 1, a vertex, t just under the minimum, a rounding tie
    tri_rows[5]  = '{'{2 * One, 2 * One, -One, '0, '0, One}, 1'b0, miss_res};
    tri_rows[6]  = '{'{'0, '0, -One, '0, '0, One}, 1'b0, miss_res};
    tri_rows[7]  = '{'{One, One, -1, '0, '0, One}, 1'b0, miss_res};
    tri_rows[8]  = '{'{One, One, -One, '0, '0, 3 * One}, 1'b0, miss_res};
    tri_rows[9]  = '{'{One, One, -One, '0, '0, 2}, 1'b0, miss_res};
    tri_rows[10] = '{'{32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
                       32'sh80000000, 32'sh80000000, 32'sh7fffffff}, 1'b0, miss_res};
    tri_rows[11] = '{'{One, One, 32'sh80000000, 32'sh7fffffff, '0, 32'sh7fffffff},
                     1'b0, miss_res};
    tri_rows[12] = '{'{One, One, -3 * One, One, One, One}, 1'b0, miss_res};
    tri_rows[13] = '{'{One, One, 32'sh80000000, '0, '0, 1}, 1'b0, miss_res};

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (reset_rows[idx]) send_ray(reset_rows[idx].ray, 1'b1, reset_rows[idx].res);
    drain();
    tri_sel = '{'0, '0, '0, 4 * One, '0, '0, '0, 4 * One, '0};
    load_triangle(tri_sel, rti_pkg::MinDistReset);
    foreach (tri_rows[idx]) begin
      send_ray(tri_rows[idx].ray, tri_rows[idx].known, tri_rows[idx].res);
    end
    drain();

    for (int ph = 0; ph < NumPhases; ph++) begin
      tri_sel = '{small_coord(), small_coord(), small_coord(), small_coord(),
                  small_coord(), small_coord(), small_coord(), small_coord(),
                  small_coord()};
      md_sel = rti_pkg::MinW'($urandom_range(0, 2 * One));
      case (ph)
        1: md_sel = '0;
        2: tri_sel = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                      $urandom(), $urandom(), $urandom(), $urandom()};
        3: md_sel = 31'h7fffffff;
        default: ;
      endcase
      load_triangle(tri_sel, md_sel);
      if (ph == NumPhases - 1) calm = 1'b1;
      // fill the pipeline against a stalled result side
      if (ph == 1) hold_left = LongHold;
      for (int n = 0; n < ItemsPerPh; n++) begin
        send_ray(aimed_ray(), 1'b0, miss_res);
        if (!calm && hold_left == 0 && $urandom_range(0, 4) == 0) idle_gap();
      end
      drain();
    end

    repeat (DrainWait) @(posedge clk_i);
    if (err_count == 0 && expected_hits.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/rti_pkg.sv
design/rti_det.sv
design/rti_div.sv
design/rti_point.sv
design/ray_triangle_intersect.sv
design/rti_checker.sv
sim/ray_triangle_intersect_tb.sv
